>>> rtl/sidtoa_pkg.sv
package sidtoa_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int ITERS_PER_STAGE = 4;
    localparam int NUM_STAGES      = VALUE_W / ITERS_PER_STAGE;
    localparam int COUNT_W         = 4;
    localparam int DPTR_W          = $clog2(DIGITS);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    // Working word of the shift-and-add-3 conversion.
    typedef struct packed {
        logic                 neg;
        bcd_t                 bcd;
        logic [VALUE_W-1:0]   bin;
    } dd_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Input channel: one beat per number on s_tvalid/s_tready, the two's complement
// value in s_tdata. Output channel: one beat per character on m_tvalid/m_tready,
// most significant character first, with a leading minus sign for negative
// values. m_tlast marks the final character of a number, and that beat carries
// the total character count in m_tdata; other beats carry a count of zero.
// The magnitude is converted by a shift-and-add-3 pipeline of one sign stage
// and eight conversion stages of four bit steps each, followed by a character
// serializer and an output register. Each number passes through every stage
// in that order. While the receiver accepts, the serializer sends one
// character per cycle, so a number occupies the output for 1 to 11 beats
// (its character count), which sets the sustained rate; the pipeline keeps
// accepting numbers until it fills. When the receiver stalls, every stage
// holds its contents and backpressure reaches s_tready; nothing is lost or
// repeated. Reset clears all valid flags; the block is ready right after it.
module signed_int_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] character, [11:8] char_count, [15:12] zero
    output logic        m_tlast
);
    import sidtoa_pkg::*;

    logic               vld [NUM_STAGES+1];
    logic               rdy [NUM_STAGES+1];
    dd_t                dat [NUM_STAGES+1];
    logic [7:0]         out_char;
    logic [COUNT_W-1:0] out_count;

    sidtoa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        sidtoa_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_data   (dat[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_data  (dat[g+1])
        );
    end

    sidtoa_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[NUM_STAGES]),
        .in_ready  (rdy[NUM_STAGES]),
        .in_neg    (dat[NUM_STAGES].neg),
        .in_bcd    (dat[NUM_STAGES].bcd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_count (out_count)
    );

    assign m_tdata = {4'd0, out_count, out_char};

endmodule

>>> rtl/sidtoa_front.sv
module sidtoa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          in_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sidtoa_pkg::dd_t      out_data
);
    import sidtoa_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.neg = in_value[VALUE_W-1];
        data_next.bcd = '0;
        data_next.bin = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/sidtoa_dabble_stage.sv
module sidtoa_dabble_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sidtoa_pkg::dd_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sidtoa_pkg::dd_t      out_data
);
    import sidtoa_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Each iteration corrects every digit of five or more, then shifts one bit in.
    always_comb begin
        data_next = in_data;
        for (int it = 0; it < ITERS_PER_STAGE; it++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (data_next.bcd[d] >= 4'd5) begin
                    data_next.bcd[d] = data_next.bcd[d] + 4'd3;
                end
            end
            {data_next.bcd, data_next.bin} = {data_next.bcd, data_next.bin} << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/sidtoa_serializer.sv
module sidtoa_serializer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_neg,
    input  sidtoa_pkg::bcd_t                  in_bcd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_char,
    output logic                              out_last,
    output logic [sidtoa_pkg::COUNT_W-1:0]    out_count
);
    import sidtoa_pkg::*;

    logic               busy_reg;
    logic               minus_reg;
    logic [DPTR_W-1:0]  dptr_reg;
    logic [COUNT_W-1:0] total_reg;
    bcd_t               bcd_reg;

    logic               ovalid_reg;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               emit;
    logic               emit_last;
    logic [7:0]         char_next;
    logic [COUNT_W-1:0] ndig;

    assign emit      = busy_reg && (!ovalid_reg || out_ready);
    assign emit_last = !minus_reg && (dptr_reg == '0);
    assign in_ready  = !busy_reg || (emit && emit_last);

    assign char_next = minus_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd_reg[dptr_reg]});

    // Position of the most significant nonzero digit; zero still prints one digit.
    always_comb begin
        ndig = COUNT_W'(1);
        for (int d = 0; d < DIGITS; d++) begin
            if (in_bcd[d] != 4'd0) begin
                ndig = COUNT_W'(d + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                busy_reg <= in_valid;
            end
            if (emit) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            minus_reg <= in_neg;
            dptr_reg  <= DPTR_W'(ndig - COUNT_W'(1));
            total_reg <= ndig + COUNT_W'(in_neg);
            bcd_reg   <= in_bcd;
        end else if (emit) begin
            if (minus_reg) begin
                minus_reg <= 1'b0;
            end else if (!emit_last) begin
                dptr_reg <= dptr_reg - DPTR_W'(1);
            end
        end
        if (emit) begin
            char_reg  <= char_next;
            last_reg  <= emit_last;
            count_reg <= emit_last ? total_reg : '0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_count = count_reg;

endmodule
